### rtl/core/wssc_pkg.sv
// Package for the window score subarray counter.
// Holds sizes, the queued item type and derived widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wssc_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int VALUE_BITS   = 17;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W       = ADDR_W + 1;
  localparam int SUM_W        = VALUE_BITS + ADDR_W;
  localparam int PROD_W       = SUM_W + LEN_W;
  localparam int LIMIT_W      = 50;
  localparam int COUNT_W      = 48;
  localparam int CMP_W        = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;
  localparam int IN_DATA_W    = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((COUNT_W + 7) / 8) * 8;

  // One input item as it waits between the front and the back.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

### rtl/core/wssc_front.sv
// Front end: accepts input requests into a two-entry queue.
// Depends on wssc_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module wssc_front
  import wssc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // [VALUE_BITS-1:0] value, rest zero
  input  wire logic                 in_tlast,   // last
  output queue_head_t               q_head,
  input  wire logic                 q_pop
);

  item_t       entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push;
  logic        pop;
  item_t       in_item;

  assign in_item.value = in_tdata[VALUE_BITS-1:0];
  assign in_item.last  = in_tlast;

  assign in_tready    = (fill_r != 2'd2);
  assign push         = in_tvalid && in_tready;
  assign pop          = q_pop && (fill_r != 2'd0);
  assign q_head.valid = (fill_r != 2'd0);
  assign q_head.item  = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/wssc_back.sv
// Back end: window ring memory, sum and length, shrink loop and running count.
// Depends on wssc_pkg for sizes and the queue head type.
`timescale 1ns / 1ps
`default_nettype none

module wssc_back
  import wssc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data,
  input  wire queue_head_t        q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COUNT_W-1:0]      out_count,
  output logic                    out_last,
  output logic                    out_overflow
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OVF  = 4'b0010,
    ST_CHK  = 4'b0100,
    ST_CMP  = 4'b1000
  } state_t;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_FULL  = LEN_W'(WINDOW_DEPTH);
  localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(WINDOW_DEPTH - 1);
  localparam logic [SLOT_W-1:0]  SLOT_WRAP = SLOT_W'(WINDOW_DEPTH);

  state_t              state_r, state_nxt;
  item_t               item_r, item_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic [ADDR_W-1:0]   oldest_r, oldest_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic [VALUE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [SLOT_W-1:0]   slot_raw;
  logic [ADDR_W-1:0]   slot;
  logic [ADDR_W-1:0]   oldest_inc;
  logic [COUNT_W:0]    count_sum;
  logic                shrink;
  logic                emit_ok;

  // Ring addressing.
  assign slot_raw   = SLOT_W'(oldest_r) + SLOT_W'(len_r);
  assign slot       = (slot_raw >= SLOT_WRAP) ? ADDR_W'(slot_raw - SLOT_WRAP)
                                              : ADDR_W'(slot_raw);
  assign oldest_inc = (oldest_r == ADDR_LAST) ? '0 : oldest_r + 1'b1;

  assign shrink    = (len_r != '0) && (CMP_W'(prod_r) >= CMP_W'(limit_r));
  assign emit_ok   = !out_valid_r || out_ready;
  assign count_sum = {1'b0, count_r} + (COUNT_W + 1)'(len_r);

  // Sequencer: insert or replace oldest, multiply and compare, shrink or emit.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    oldest_nxt    = oldest_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slot;
    wr_data       = item_r.value;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop    = 1'b1;
          item_nxt = q_head.item;
          if (len_r == LEN_FULL) begin
            state_nxt = ST_OVF;
          end else begin
            wr_en     = 1'b1;
            wr_data   = q_head.item.value;
            len_nxt   = len_r + 1'b1;
            sum_nxt   = sum_r + SUM_W'(q_head.item.value);
            state_nxt = ST_CHK;
          end
        end
      end
      ST_OVF: begin
        // Oldest value leaves, new value takes its slot.
        wr_en      = 1'b1;
        wr_addr    = oldest_r;
        sum_nxt    = sum_r - SUM_W'(rd_data_r) + SUM_W'(item_r.value);
        oldest_nxt = oldest_inc;
        ovf_nxt    = 1'b1;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        prod_nxt  = sum_r * len_r;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (shrink) begin
          sum_nxt    = sum_r - SUM_W'(rd_data_r);
          oldest_nxt = oldest_inc;
          len_nxt    = len_r - 1'b1;
          state_nxt  = ST_CHK;
        end else if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
          out_last_nxt  = item_r.last;
          out_ovf_nxt   = ovf_r;
          count_nxt     = out_count_nxt;
          state_nxt     = ST_IDLE;
          if (item_r.last) begin
            oldest_nxt = '0;
            len_nxt    = '0;
            sum_nxt    = '0;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_W'(1);
      oldest_r    <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      len_r       <= len_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    prod_r      <= prod_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Window ring memory: one write port, one registered read of the oldest entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[oldest_r];
  end

  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  // The window never holds more entries than the ring.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("window length above ring depth");

  // An empty window carries no sum.
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) |-> (sum_r == '0))
    else $error("empty window with nonzero sum");

  // Each shrink step removes exactly one entry.
  a_shrink_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && shrink) |=> (len_r == $past(len_r) - 1'b1))
    else $error("shrink step did not remove one entry");

  // Closing an array clears the window and the count.
  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && !shrink && emit_ok && item_r.last)
      |=> (len_r == '0 && count_r == '0 && !ovf_r))
    else $error("array state not cleared after last item");

endmodule

`default_nettype wire

### rtl/core/window_score_subarray_counter.sv
// An accepted request waits in the front queue, then the sequencer inserts its value, first
// dropping the oldest value on a full window, and repeats multiply and compare for every value
// that leaves the window; the result sits in an output register. Items are handled one at a
// time, set by the multiply-compare loop over the single read port of the window memory.
// Reset: synchronous, active low; clears window length, sum, count and flags and sets the
// limit to 1. The window memory is not cleared: entries are read only after being written.
`timescale 1ns / 1ps
`default_nettype none

module window_score_subarray_counter
  import wssc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]    cfg_wr_data,   // score_limit
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,      // value, zero padding above
  input  wire logic                  in_tlast,      // last
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,     // count
  output logic                       out_tlast,     // last_res
  output logic                       out_tuser      // overflow
);

  queue_head_t          q_head;
  logic                 q_pop;
  logic [COUNT_W-1:0]   count;

  wssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  wssc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_count    (count),
    .out_last     (out_tlast),
    .out_overflow (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(count);

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for window_score_subarray_counter.
// Depends on wssc_pkg and the block's RTL; a built-in predictor tracks the window and count.
`timescale 1ns / 1ps

module tb_top;
  import wssc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam longint unsigned LIMIT_MAX = (64'd1 << LIMIT_W) - 64'd1;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [VALUE_BITS-1:0] VALUE_TOP = '1;

  // One expected result.
  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               overflow;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;     // value, zero padding above
  logic                  in_tlast = 1'b0;   // last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // count
  logic                  out_tlast;         // last_res
  logic                  out_tuser;         // overflow

  window_score_subarray_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Request and result queues shared by the stimulus, the driver and the monitors.
  item_t  pending_items[$];
  tally_t expected_tallies[$];

  // Predictor state: the window ring, its sum and length, the running count.
  logic [VALUE_BITS-1:0] win_vals [WINDOW_DEPTH];
  int unsigned           win_oldest = 0;
  int unsigned           win_len = 0;
  longint unsigned       win_sum = 0;
  longint unsigned       run_count = 0;
  logic                  ovf_seen = 1'b0;
  longint unsigned       limit_copy = 1;

  // Knobs set by the stimulus process.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    fail_count++;
  endtask

  // Add one value to the window, shrink it below the limit and extend the count.
  task automatic tally_subarrays(input logic [VALUE_BITS-1:0] value, input logic last);
    tally_t t;
    if (win_len >= WINDOW_DEPTH) begin
      win_sum -= win_vals[win_oldest];
      win_oldest = (win_oldest + 1) % WINDOW_DEPTH;
      win_len--;
      ovf_seen = 1'b1;
    end
    win_vals[(win_oldest + win_len) % WINDOW_DEPTH] = value;
    win_len++;
    win_sum += value;
    // Sum times length stays far below 64 bits at these widths.
    while (win_len != 0 && win_sum * win_len >= limit_copy) begin
      win_sum -= win_vals[win_oldest];
      win_oldest = (win_oldest + 1) % WINDOW_DEPTH;
      win_len--;
    end
    if (run_count > COUNT_MAX - win_len) run_count = COUNT_MAX;
    else run_count += win_len;
    t.count = run_count[COUNT_W-1:0];
    t.last = last;
    t.overflow = ovf_seen;
    expected_tallies.push_back(t);
    if (last) begin
      win_oldest = 0;
      win_len = 0;
      win_sum = 0;
      run_count = 0;
      ovf_seen = 1'b0;
    end
  endtask

  // Input driver: offers queued items, with random idle bursts between them.
  item_t       next_item;
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= IN_DATA_W'(next_item.value);
        in_tlast <= next_item.last;
        if (!calm && $urandom_range(99) < gap_pct) in_gap <= $urandom_range(13, 1);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Input monitor: every accepted request feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tally_subarrays(in_tdata[VALUE_BITS-1:0], in_tlast);
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  int unsigned out_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (out_gap != 0) begin
      out_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      out_tready <= 1'b0;
      out_gap <= $urandom_range(12, 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  tally_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("unexpected result count", out_tdata, 0);
      end else begin
        want = expected_tallies.pop_front();
        if (out_tdata !== want.count) report_mismatch("count", out_tdata, want.count);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
        if (out_tuser !== want.overflow) report_mismatch("overflow", out_tuser, want.overflow);
      end
      results_seen++;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] value, input logic last);
    item_t it;
    it.value = value;
    it.last = last;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_items.size() == 0 && !in_tvalid && expected_tallies.size() == 0));
  endtask

  // The block is idle here, so the predictor may take the new limit at once.
  task automatic write_limit(input longint unsigned lim);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim[LIMIT_W-1:0];
    limit_copy = lim & LIMIT_MAX;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Queue whole arrays of random values, n_items in total.
  task automatic queue_arrays(input int unsigned n_items, input int unsigned vbits);
    int unsigned left;
    int unsigned alen;
    longint unsigned vmax;
    logic [VALUE_BITS-1:0] v;
    left = n_items;
    vmax = (64'd1 << vbits) - 64'd1;
    while (left != 0) begin
      alen = ($urandom_range(9) == 0) ? 1 : $urandom_range(64, 2);
      if (alen > left) alen = left;
      for (int unsigned i = 0; i < alen; i++) begin
        // Occasional full-scale spikes break the window down.
        if ($urandom_range(19) == 0) v = VALUE_TOP;
        else v = VALUE_BITS'($urandom_range(32'(vmax), 1));
        send_value(v, i == alen - 1);
      end
      left -= alen;
    end
  endtask

  initial begin
    int unsigned vbits;
    int unsigned wlen;
    longint unsigned lim;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset limit of 1: every window empties at once.
    send_value(1, 1'b0);
    send_value(VALUE_TOP, 1'b1);

    // Zero limit, with a zero value in the array.
    write_limit(0);
    send_value(5, 1'b0);
    send_value(0, 1'b0);
    send_value(VALUE_TOP, 1'b1);

    // Moderate limit: growing and shrinking windows, then a single-item array and a two-item array.
    write_limit(1000);
    send_value(1, 1'b0);
    send_value(2, 1'b0);
    send_value(3, 1'b0);
    send_value(0, 1'b0);
    send_value(4, 1'b0);
    send_value(100, 1'b0);
    send_value(1, 1'b0);
    send_value(1, 1'b1);
    send_value(7, 1'b1);
    send_value(VALUE_TOP, 1'b0);
    send_value(5, 1'b1);

    // Largest limit: the window only ever grows.
    write_limit(LIMIT_MAX);
    send_value(VALUE_TOP, 1'b0);
    send_value(VALUE_TOP, 1'b0);
    send_value(VALUE_TOP, 1'b0);
    send_value(1, 1'b1);

    // Window full: more values than the ring holds, then a short array after it.
    gap_pct = 10;
    stall_pct = 10;
    for (int unsigned i = 0; i < WINDOW_DEPTH + 6; i++)
      send_value(VALUE_BITS'($urandom_range(32'(VALUE_TOP), 1)), i == WINDOW_DEPTH + 5);
    for (int unsigned i = 0; i < 5; i++) send_value(VALUE_BITS'($urandom_range(50, 1)), i == 4);

    // Random phases, each with its own limit and value range.
    for (int unsigned phase = 0; phase < 8; phase++) begin
      vbits = (phase % 3 == 0) ? VALUE_BITS : $urandom_range(VALUE_BITS, 1);
      wlen = $urandom_range(48, 1);
      lim = longint'($urandom_range(32'((64'd1 << vbits) - 64'd1), 1)) * wlen * wlen;
      write_limit(lim);
      calm = (phase == 7);
      gap_pct = $urandom_range(2) * 15;
      stall_pct = $urandom_range(2) * 15;
      queue_arrays(62, vbits);
      // Stall the results for a long stretch while requests keep arriving.
      if (phase == 2) hold_req = 1'b1;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
